@@ sv/bftm_pkg.sv @@
// Package for the tape machine: command codes, phases, status codes and widths.
// Used by bf_tape_machine_core; depends on nothing.
package bftm_pkg;

  localparam int CodeDepth = 1024;
  localparam int TapeDepth = 4096;
  localparam int NestDepth = 64;
  localparam int CodeAw    = $clog2(CodeDepth);
  localparam int TapeAw    = $clog2(TapeDepth);
  localparam int NestAw    = $clog2(NestDepth);

  typedef enum logic [2:0] {
    OP_RIGHT = 3'd0,
    OP_LEFT  = 3'd1,
    OP_INC   = 3'd2,
    OP_DEC   = 3'd3,
    OP_OUT   = 3'd4,
    OP_IN    = 3'd5,
    OP_OPEN  = 3'd6,
    OP_CLOSE = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_START = 2'd1,
    ACT_STEP  = 2'd2,
    ACT_NOP   = 2'd3
  } act_e;

  typedef enum logic [1:0] {
    PH_LOAD      = 2'd0,
    PH_ERR_CLOSE = 2'd1,
    PH_RUN       = 2'd2,
    PH_ERR_OVF   = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_UNMATCHED = 3'd1,
    ST_UNCLOSED  = 3'd2,
    ST_HALTED    = 3'd3,
    ST_OVERFLOW  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLOSE_RD,
    S_CLEAR,
    S_EXEC_RD,
    S_EXEC,
    S_OUT
  } state_e;

  typedef struct packed {
    logic [2:0] status;
    logic [6:0] open_count;
    logic       out_valid;
    logic [7:0] out_byte;
    logic       took_input;
  } result_t;

  function automatic logic [3:0] decode_char(input logic [7:0] c);
    logic [3:0] r;
    r = 4'b0000;
    case (c)
      8'h3E: r = {1'b1, OP_RIGHT};
      8'h3C: r = {1'b1, OP_LEFT};
      8'h2B: r = {1'b1, OP_INC};
      8'h2D: r = {1'b1, OP_DEC};
      8'h2E: r = {1'b1, OP_OUT};
      8'h2C: r = {1'b1, OP_IN};
      8'h5B: r = {1'b1, OP_OPEN};
      8'h5D: r = {1'b1, OP_CLOSE};
      default: r = 4'b0000;
    endcase
    return r;
  endfunction

endpackage

@@ sv/bf_tape_machine_core.sv @@
// Top level of the tape machine: control sequencer and the four memories.
// Depends on bftm_pkg and bftm_ram.
//
//  channel  | dir | tdata (low bit up)                         | tuser
//  s_axis   | in  | [1:0] action, [9:2] char_or_byte, pad to 16 | -
//  m_axis   | out | [2:0] status, [9:3] open_count, [10] out_valid,
//           |     | [18:11] out_byte, [19] took_input, pad to 24 | -
//
// A load result is valid the cycle after its transfer; for a ']' it is loaded
// in S_CLOSE_RD, after the bracket stack top is read.
// A step result passes through S_EXEC_RD, while the code, jump and tape reads
// land, then S_EXEC, which writes the cell back and sets the result, and S_OUT,
// which raises the result valid. A successful start clears the tape, one cell
// a cycle, before its result is shown.
// After reset the tape is zero through the same clearing pass, while no item
// is taken. One item is in work at a time; a held result stalls the next
// acceptance.
module bf_tape_machine_core
  import bftm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // action, char_or_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // status, open_count, out_valid, out_byte, took_input
);

  state_e state_q, state_d;
  phase_e phase_q, phase_d;
  logic [NestAw:0] sc_q, sc_d;
  logic [CodeAw:0] len_q, len_d;
  logic [CodeAw:0] pc_q, pc_d;
  logic [TapeAw-1:0] tp_q, tp_d;
  logic [TapeAw-1:0] clr_q, clr_d;
  logic [7:0] byte_q, byte_d;
  result_t res_q, res_d;
  logic ovalid_q, ovalid_d;

  logic acc;
  logic [1:0] act;
  logic [7:0] din;
  logic [3:0] dec;

  // memory ports
  logic code_we, jt_we, stk_we, tape_we;
  logic [CodeAw-1:0] code_wa, code_ra, jt_wa, jt_ra;
  logic [2:0] code_wd, code_rd;
  logic [CodeAw-1:0] jt_wd, jt_rd;
  logic [NestAw-1:0] stk_wa, stk_ra;
  logic [CodeAw-1:0] stk_wd, stk_rd;
  logic [TapeAw-1:0] tape_wa, tape_ra;
  logic [7:0] tape_wd, tape_rd;
  // second jump-table write for a ']' goes in the following cycle, from jt2_q
  logic jt2_q, jt2_d;
  logic [CodeAw-1:0] jt2a_q, jt2a_d, jt2v_q, jt2v_d;

  assign act = s_axis_tdata[1:0];
  assign din = s_axis_tdata[9:2];
  assign dec = decode_char(din);
  assign s_axis_tready = (state_q == S_IDLE) && !ovalid_q && !jt2_q;
  assign acc = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata = {4'd0, res_q.took_input, res_q.out_byte, res_q.out_valid,
                         res_q.open_count, res_q.status};

  bftm_ram #(.Width(3), .Depth(CodeDepth)) u_code (
    .clk_i, .we_i(code_we), .waddr_i(code_wa), .wdata_i(code_wd),
    .raddr_i(code_ra), .rdata_o(code_rd));
  bftm_ram #(.Width(CodeAw), .Depth(CodeDepth)) u_jump (
    .clk_i, .we_i(jt_we), .waddr_i(jt_wa), .wdata_i(jt_wd),
    .raddr_i(jt_ra), .rdata_o(jt_rd));
  bftm_ram #(.Width(CodeAw), .Depth(NestDepth)) u_stack (
    .clk_i, .we_i(stk_we), .waddr_i(stk_wa), .wdata_i(stk_wd),
    .raddr_i(stk_ra), .rdata_o(stk_rd));
  bftm_ram #(.Width(8), .Depth(TapeDepth)) u_tape (
    .clk_i, .we_i(tape_we), .waddr_i(tape_wa), .wdata_i(tape_wd),
    .raddr_i(tape_ra), .rdata_o(tape_rd));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      phase_q  <= PH_LOAD;
      sc_q     <= '0;
      len_q    <= '0;
      pc_q     <= '0;
      tp_q     <= '0;
      clr_q    <= '0;
      ovalid_q <= 1'b0;
      jt2_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      phase_q  <= phase_d;
      sc_q     <= sc_d;
      len_q    <= len_d;
      pc_q     <= pc_d;
      tp_q     <= tp_d;
      clr_q    <= clr_d;
      ovalid_q <= ovalid_d;
      jt2_q    <= jt2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    res_q  <= res_d;
    jt2a_q <= jt2a_d;
    jt2v_q <= jt2v_d;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (acc) begin
          if (act == ACT_LOAD && phase_q == PH_LOAD && dec[3] &&
              dec[2:0] == OP_CLOSE && sc_q != '0 && len_q < CodeDepth) begin
            state_d = S_CLOSE_RD;
          end else if (act == ACT_START && (phase_q == PH_LOAD || phase_q == PH_RUN) &&
                       sc_q == '0) begin
            state_d = S_CLEAR;
          end else if (act == ACT_STEP && phase_q == PH_RUN && pc_q < len_q) begin
            state_d = S_EXEC_RD;
          end
        end
      end
      S_CLOSE_RD: state_d = S_IDLE;
      S_CLEAR:    if (clr_q == TapeAw'(TapeDepth - 1)) state_d = S_IDLE;
      S_EXEC_RD:  state_d = S_EXEC;
      S_EXEC:     state_d = S_OUT;
      S_OUT:      state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    phase_d  = phase_q;
    sc_d     = sc_q;
    len_d    = len_q;
    pc_d     = pc_q;
    tp_d     = tp_q;
    clr_d    = clr_q;
    byte_d   = byte_q;
    res_d    = res_q;
    ovalid_d = ovalid_q && !m_axis_tready;
    jt2_d    = 1'b0;
    jt2a_d   = jt2a_q;
    jt2v_d   = jt2v_q;
    code_we  = 1'b0;
    code_wa  = len_q[CodeAw-1:0];
    code_wd  = dec[2:0];
    code_ra  = pc_q[CodeAw-1:0];
    jt_we    = jt2_q;
    jt_wa    = jt2a_q;
    jt_wd    = jt2v_q;
    jt_ra    = pc_q[CodeAw-1:0];
    stk_we   = 1'b0;
    stk_wa   = sc_q[NestAw-1:0];
    stk_wd   = len_q[CodeAw-1:0];
    stk_ra   = NestAw'(sc_q - 1'b1);
    tape_we  = 1'b0;
    tape_wa  = tp_q;
    tape_wd  = byte_q;
    tape_ra  = tp_q;

    unique case (state_q)
      S_IDLE: begin
        if (acc) begin
          byte_d = din;
          res_d = '0;
          ovalid_d = 1'b1;
          if (phase_q == PH_ERR_CLOSE && act != ACT_NOP) begin
            res_d.status = ST_UNMATCHED;
          end else if (phase_q == PH_ERR_OVF && act != ACT_NOP) begin
            res_d.status = ST_OVERFLOW;
          end
          if (act == ACT_START) begin
            res_d.open_count = 7'(sc_q);
          end
          unique case (act)
            ACT_LOAD: begin
              if (phase_q == PH_LOAD && dec[3]) begin
                if (dec[2:0] == OP_CLOSE && sc_q == '0) begin
                  phase_d = PH_ERR_CLOSE;
                  res_d.status = ST_UNMATCHED;
                end else if (len_q >= CodeDepth ||
                             (dec[2:0] == OP_OPEN && sc_q >= NestDepth)) begin
                  phase_d = PH_ERR_OVF;
                  res_d.status = ST_OVERFLOW;
                end else if (dec[2:0] == OP_CLOSE) begin
                  ovalid_d = 1'b0;   // finished after the stack read
                end else begin
                  code_we = 1'b1;
                  len_d = len_q + 1'b1;
                  if (dec[2:0] == OP_OPEN) begin
                    stk_we = 1'b1;
                    sc_d = sc_q + 1'b1;
                  end
                end
              end
            end
            ACT_START: begin
              if ((phase_q == PH_LOAD || phase_q == PH_RUN) && sc_q != '0) begin
                res_d.status = ST_UNCLOSED;
              end else if (phase_q == PH_LOAD || phase_q == PH_RUN) begin
                ovalid_d = 1'b0;     // shown after the tape is cleared
                clr_d = '0;
                tp_d = '0;
                pc_d = '0;
                phase_d = PH_RUN;
              end
            end
            ACT_STEP: begin
              if (phase_q == PH_LOAD || (phase_q == PH_RUN && pc_q >= len_q)) begin
                res_d.status = ST_HALTED;
              end else if (phase_q == PH_RUN) begin
                ovalid_d = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
      S_CLOSE_RD: begin
        // stack top is in stk_rd; pair the brackets
        code_we = 1'b1;
        code_wd = OP_CLOSE;
        jt_we = 1'b1;
        jt_wa = len_q[CodeAw-1:0];
        jt_wd = stk_rd;
        jt2_d = 1'b1;
        jt2a_d = stk_rd;
        jt2v_d = len_q[CodeAw-1:0];
        sc_d = sc_q - 1'b1;
        len_d = len_q + 1'b1;
        ovalid_d = 1'b1;
      end
      S_CLEAR: begin
        tape_we = 1'b1;
        tape_wa = clr_q;
        tape_wd = 8'd0;
        clr_d = clr_q + 1'b1;
        if (clr_q == TapeAw'(TapeDepth - 1)) begin
          clr_d = '0;
          // Only a start transfer owes a result; the pass after reset does not.
          ovalid_d = (phase_q == PH_RUN);
        end
      end
      S_EXEC_RD: ;  // code, jump and tape reads are in flight
      S_EXEC: begin
        pc_d = pc_q + 1'b1;
        unique case (op_e'(code_rd))
          OP_RIGHT: tp_d = (tp_q == TapeAw'(TapeDepth - 1)) ? '0 : tp_q + 1'b1;
          OP_LEFT:  tp_d = (tp_q == '0) ? TapeAw'(TapeDepth - 1) : tp_q - 1'b1;
          OP_INC: begin
            tape_we = 1'b1;
            tape_wd = tape_rd + 8'd1;
          end
          OP_DEC: begin
            tape_we = 1'b1;
            tape_wd = tape_rd - 8'd1;
          end
          OP_OUT: begin
            res_d.out_valid = 1'b1;
            res_d.out_byte = tape_rd;
          end
          OP_IN: begin
            tape_we = 1'b1;
            tape_wd = byte_q;
            res_d.took_input = 1'b1;
          end
          OP_OPEN:  if (tape_rd == 8'd0) pc_d = {1'b0, jt_rd} + 1'b1;
          OP_CLOSE: if (tape_rd != 8'd0) pc_d = {1'b0, jt_rd} + 1'b1;
          default: ;
        endcase
      end
      S_OUT: ovalid_d = 1'b1;
      default: ;
    endcase
  end

  // The bracket stack never holds more entries than the nesting limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni) sc_q <= NestDepth)
    else $error("bracket stack count beyond limit");
  // A new item is never accepted while a result is still held.
  assert property (@(posedge clk_i) disable iff (!rst_ni) ovalid_q |-> !s_axis_tready)
    else $error("accept while result pending");
  // S_OUT is always followed by a valid step result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT) |=> ovalid_q)
    else $error("step result missing");
  // The stored code length never exceeds the store depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni) len_q <= CodeDepth)
    else $error("code length beyond store");

endmodule

@@ sv/bftm_ram.sv @@
// Generic single-port-write, single-port-read synchronous RAM, registered read.
// Standalone; no package needed.
module bftm_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
